// ===== rtl/mm4_pkg.sv =====
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
`timescale 1ns / 1ps

package mm4_pkg;

	// Matrix dimension and element format.
	localparam int DIM           = 4;
	localparam int ROW_W         = $clog2(DIM);
	localparam int DATA_W        = 16;
	localparam int PROD_W        = 2 * DATA_W;
	localparam int ACC_W         = PROD_W + ROW_W;
	localparam int FRAC_BITS_DEF = 8;

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(DIM - 1);

	typedef logic signed [DATA_W-1:0] elem_t;
	typedef elem_t [DIM-1:0]          row_t;

	// One input word: row r of A and row r of B.
	typedef struct packed {
		elem_t a_col0;
		elem_t a_col1;
		elem_t a_col2;
		elem_t a_col3;
		elem_t b_col0;
		elem_t b_col1;
		elem_t b_col2;
		elem_t b_col3;
	} in_item_t;

	// One result word: a row of C.
	typedef struct packed {
		elem_t c_col0;
		elem_t c_col1;
		elem_t c_col2;
		elem_t c_col3;
		logic  last_row;
	} out_item_t;

	// Kind of word that travels down the cell chain.
	typedef enum logic {
		WK_LOAD = 1'b0,
		WK_MUL  = 1'b1
	} kind_t;

	// Word handed from cell to cell.
	typedef struct packed {
		kind_t            kind;
		logic [ROW_W-1:0] row;
		logic             last;
		row_t             data;
		row_t             c;
	} chain_t;

endpackage

// ===== rtl/mm4_cell.sv =====
// One column cell of the multiplier chain: holds a column of B and fills one element of C.
`timescale 1ns / 1ps

module mm4_cell #(
	parameter int COL       = 0,
	parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  mm4_pkg::chain_t in_word,
	output logic            out_valid,
	output mm4_pkg::chain_t out_word
);

	localparam int DIM    = mm4_pkg::DIM;
	localparam int PROD_W = mm4_pkg::PROD_W;
	localparam int ACC_W  = mm4_pkg::ACC_W;
	localparam int DATA_W = mm4_pkg::DATA_W;

	localparam logic signed [ACC_W-1:0] SAT_MAX =
		ACC_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

	// Column COL of matrix B, one entry per row.
	mm4_pkg::elem_t bcol_q [DIM];

	logic                     valid_s1;
	mm4_pkg::chain_t          word_s1;
	logic signed [PROD_W-1:0] prod_s1 [DIM];

	logic                     valid_s2;
	mm4_pkg::chain_t          word_s2;

	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  acc_sh;
	logic signed [ACC_W-1:0]  acc_sat;
	mm4_pkg::chain_t          word_fill;

	// A load word writes this cell's element of the B row it carries.
	always_ff @(posedge clk) begin
		if (in_valid && in_word.kind == mm4_pkg::WK_LOAD) begin
			bcol_q[in_word.row] <= in_word.data[COL];
		end
	end

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage one: the four products of the A row with the stored column.
	always_ff @(posedge clk) begin
		word_s1 <= in_word;
		for (int k = 0; k < DIM; k++) begin
			prod_s1[k] <= $signed(in_word.data[k]) * $signed(bcol_q[k]);
		end
	end

	// Stage two: sum at full precision, arithmetic shift, saturate.
	always_comb begin
		acc = '0;
		for (int k = 0; k < DIM; k++) begin
			acc = acc + ACC_W'(prod_s1[k]);
		end
		acc_sh = acc >>> FRAC_BITS;
		if (acc_sh > SAT_MAX) begin
			acc_sat = SAT_MAX;
		end else if (acc_sh < SAT_MIN) begin
			acc_sat = SAT_MIN;
		end else begin
			acc_sat = acc_sh;
		end
		word_fill        = word_s1;
		word_fill.c[COL] = acc_sat[DATA_W-1:0];
	end

	always_ff @(posedge clk) begin
		word_s2 <= word_fill;
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

endmodule

// ===== rtl/matrix4_multiply.sv =====
// Top level of the 4x4 matrix multiplier: row loader, issue sequencer and cell chain.
// After four input words, busy is high while the rows of A are issued into the four-cell
// chain, and no input word is taken. The rows of C then leave the chain back to back in
// row order, one per cycle; the next matrix can be loaded while earlier rows of C are
// still travelling through the chain.
// Reset clears the row counter, the sequencer and all valid bits; the matrix stores are
// not cleared. The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module matrix4_multiply #(
	parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mm4_pkg::in_item_t  item,
	output logic               busy,
	output logic               strobe,
	output mm4_pkg::out_item_t result
);

	localparam int DIM   = mm4_pkg::DIM;
	localparam int ROW_W = mm4_pkg::ROW_W;

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_ISSUE = 2'b10
	} state_t;

	state_t             state_q;
	logic [ROW_W-1:0]   row_cnt_q;
	logic [ROW_W-1:0]   issue_cnt_q;
	logic               iss_valid_q;
	mm4_pkg::chain_t    iss_word_q;
	mm4_pkg::chain_t    iss_word_next;
	mm4_pkg::row_t      a_store_q [DIM];
	mm4_pkg::row_t      a_row_in;
	mm4_pkg::row_t      b_row_in;
	logic               accept;

	logic               chain_valid [DIM+1];
	mm4_pkg::chain_t    chain_word  [DIM+1];

	assign busy   = (state_q == ST_ISSUE);
	assign accept = start && !busy;

	// Unpack the incoming rows into element order.
	assign a_row_in[0] = item.a_col0;
	assign a_row_in[1] = item.a_col1;
	assign a_row_in[2] = item.a_col2;
	assign a_row_in[3] = item.a_col3;
	assign b_row_in[0] = item.b_col0;
	assign b_row_in[1] = item.b_col1;
	assign b_row_in[2] = item.b_col2;
	assign b_row_in[3] = item.b_col3;

	// Sequencer: count loaded rows, then issue the four rows of A.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			row_cnt_q   <= '0;
			issue_cnt_q <= '0;
			iss_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					iss_valid_q <= start;
					if (start) begin
						row_cnt_q <= row_cnt_q + ROW_W'(1);
						if (row_cnt_q == mm4_pkg::ROW_LAST) begin
							state_q     <= ST_ISSUE;
							issue_cnt_q <= '0;
						end
					end
				end
				ST_ISSUE: begin
					iss_valid_q <= 1'b1;
					issue_cnt_q <= issue_cnt_q + ROW_W'(1);
					if (issue_cnt_q == mm4_pkg::ROW_LAST) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q     <= ST_LOAD;
					iss_valid_q <= 1'b0;
				end
			endcase
		end
	end

	// Next word for the chain: a B row to load, or an A row to multiply.
	always_comb begin
		iss_word_next      = '0;
		iss_word_next.kind = mm4_pkg::WK_LOAD;
		iss_word_next.row  = row_cnt_q;
		iss_word_next.data = b_row_in;
		if (busy) begin
			iss_word_next.kind = mm4_pkg::WK_MUL;
			iss_word_next.row  = issue_cnt_q;
			iss_word_next.last = (issue_cnt_q == mm4_pkg::ROW_LAST);
			iss_word_next.data = a_store_q[issue_cnt_q];
		end
	end

	// Store the A row and register the chain word.
	always_ff @(posedge clk) begin
		if (accept) begin
			a_store_q[row_cnt_q] <= a_row_in;
		end
		iss_word_q <= iss_word_next;
	end

	assign chain_valid[0] = iss_valid_q;
	assign chain_word[0]  = iss_word_q;

	// Chain of column cells; each fills its element of the C row passing through.
	for (genvar j = 0; j < DIM; j++) begin : g_cell
		mm4_cell #(
			.COL       (j),
			.FRAC_BITS (FRAC_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[j]),
			.in_word   (chain_word[j]),
			.out_valid (chain_valid[j+1]),
			.out_word  (chain_word[j+1])
		);
	end

	// Results leave the last cell's output register.
	assign strobe          = chain_valid[DIM] && (chain_word[DIM].kind == mm4_pkg::WK_MUL);
	assign result.c_col0   = chain_word[DIM].c[0];
	assign result.c_col1   = chain_word[DIM].c[1];
	assign result.c_col2   = chain_word[DIM].c[2];
	assign result.c_col3   = chain_word[DIM].c[3];
	assign result.last_row = chain_word[DIM].last;

	// Taking the fourth row starts the issue phase.
	a_issue_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && row_cnt_q == mm4_pkg::ROW_LAST |=> busy)
		else $error("issue phase did not start after the fourth row");

	// The issue phase ends after the last row of A.
	a_issue_end: assert property (@(posedge clk) disable iff (!arst_n)
		busy && issue_cnt_q == mm4_pkg::ROW_LAST |=> !busy)
		else $error("issue phase ran past the last row");

	// A row that is not the last is followed by another result word.
	a_rows_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_row |=> strobe)
		else $error("result rows are not back to back");

	// The last row comes after three other result words.
	a_last_after_three: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_row |->
			$past(strobe, 1) && $past(strobe, 2) && $past(strobe, 3))
		else $error("last row flagged too early");

endmodule

// ===== bench/mm4_product_checker.sv =====
// Checker for the 4x4 matrix multiplier: predicts product rows and compares them with the block.
`timescale 1ns / 1ps

module mm4_product_checker #(
	parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  mm4_pkg::in_item_t  item,
	input  logic               strobe,
	input  mm4_pkg::out_item_t result,
	output int                 fail_count,
	output int                 pending,
	output int                 rows_checked,
	output int                 sat_elems
);

	// Local copy of both operand matrices and of the row being filled.
	mm4_pkg::elem_t              a_rows [mm4_pkg::DIM][mm4_pkg::DIM];
	mm4_pkg::elem_t              b_rows [mm4_pkg::DIM][mm4_pkg::DIM];
	logic [mm4_pkg::ROW_W-1:0]   fill_row;

	// Product rows that the block still owes, oldest first.
	mm4_pkg::out_item_t          expected_rows [$];

	int               fails   = 0;
	int               shown   = 0;
	int               checked = 0;
	int               sats    = 0;

	// One element of C: full-precision dot product, arithmetic shift, then clamp to 16 bits.
	function automatic mm4_pkg::elem_t dot_sat(int i, int j);
		longint acc;
		longint scaled;
		acc = 0;
		for (int k = 0; k < mm4_pkg::DIM; k++)
			acc += longint'(a_rows[i][k]) * longint'(b_rows[k][j]);
		scaled = acc >>> FRAC_BITS;
		if (scaled > 32767) begin
			sats++;
			return mm4_pkg::elem_t'(32767);
		end
		if (scaled < -32768) begin
			sats++;
			return mm4_pkg::elem_t'(-32768);
		end
		return mm4_pkg::elem_t'(scaled);
	endfunction

	// Compare each result word with the oldest prediction, then take in any accepted input word.
	always @(posedge clk or negedge arst_n) begin : watch
		mm4_pkg::out_item_t want;
		if (!arst_n) begin
			fill_row = '0;
			expected_rows.delete();
		end else begin
			if (strobe) begin
				if (expected_rows.size() == 0) begin
					fails++;
					if (shown < 10)
						$display("%0t: unexpected result word c=%0d %0d %0d %0d last=%0b",
							$realtime, result.c_col0, result.c_col1, result.c_col2,
							result.c_col3, result.last_row);
					shown++;
				end else begin
					want = expected_rows.pop_front();
					checked++;
					if (result.c_col0 !== want.c_col0 || result.c_col1 !== want.c_col1 ||
						result.c_col2 !== want.c_col2 || result.c_col3 !== want.c_col3 ||
						result.last_row !== want.last_row) begin
						fails++;
						if (shown < 10)
							$display("%0t: row mismatch exp c=%0d %0d %0d %0d last=%0b, got c=%0d %0d %0d %0d last=%0b",
								$realtime, want.c_col0, want.c_col1, want.c_col2,
								want.c_col3, want.last_row, result.c_col0, result.c_col1,
								result.c_col2, result.c_col3, result.last_row);
						shown++;
					end
				end
			end
			if (start && !busy) begin
				a_rows[fill_row][0] = item.a_col0;
				a_rows[fill_row][1] = item.a_col1;
				a_rows[fill_row][2] = item.a_col2;
				a_rows[fill_row][3] = item.a_col3;
				b_rows[fill_row][0] = item.b_col0;
				b_rows[fill_row][1] = item.b_col1;
				b_rows[fill_row][2] = item.b_col2;
				b_rows[fill_row][3] = item.b_col3;
				// The fourth row completes both matrices: all of C becomes due.
				if (fill_row == mm4_pkg::ROW_LAST) begin
					for (int i = 0; i < mm4_pkg::DIM; i++) begin
						want.c_col0   = dot_sat(i, 0);
						want.c_col1   = dot_sat(i, 1);
						want.c_col2   = dot_sat(i, 2);
						want.c_col3   = dot_sat(i, 3);
						want.last_row = (i == mm4_pkg::DIM - 1);
						expected_rows.push_back(want);
					end
				end
				fill_row = fill_row + mm4_pkg::ROW_W'(1);
			end
		end
		pending      <= expected_rows.size();
		fail_count   <= fails;
		rows_checked <= checked;
		sat_elems    <= sats;
	end

endmodule

// ===== bench/tb.sv =====
// Top of the matrix multiplier testbench: clock, reset, operand stimulus and verdict.
`timescale 1ns / 1ps

module tb;

	localparam int IDLE_LIMIT = 500;
	localparam int RAND_MATS  = 48;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	mm4_pkg::in_item_t  item;
	logic               busy;
	logic               strobe;
	mm4_pkg::out_item_t result;

	int        fail_count;
	int        pending;
	int        rows_checked;
	int        sat_elems;

	int        idle_cycles;
	int        burst_left;
	int        words_sent;
	int        mats_sent;
	mm4_pkg::elem_t mat_a [mm4_pkg::DIM][mm4_pkg::DIM];
	mm4_pkg::elem_t mat_b [mm4_pkg::DIM][mm4_pkg::DIM];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	matrix4_multiply dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	mm4_product_checker u_product_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.strobe       (strobe),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending),
		.rows_checked (rows_checked),
		.sat_elems    (sat_elems)
	);

	// Count cycles in which no word moves in either direction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((start && !busy) || strobe)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// Watchdog: give up when the block has been stuck too long.
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("Watchdog expired after %0d quiet cycles.", IDLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Random operand element in one of three flavors: full range, small, or edge values.
	function automatic mm4_pkg::elem_t rand_elem(int style);
		case (style)
			0: return mm4_pkg::elem_t'($urandom);
			1: return mm4_pkg::elem_t'(int'($urandom_range(0, 2048)) - 1024);
			default: begin
				case ($urandom_range(0, 7))
					0: return mm4_pkg::elem_t'(-32768);
					1: return mm4_pkg::elem_t'(32767);
					2: return mm4_pkg::elem_t'(0);
					3: return mm4_pkg::elem_t'(-1);
					4: return mm4_pkg::elem_t'(256);
					5: return mm4_pkg::elem_t'(-256);
					default: return mm4_pkg::elem_t'($urandom);
				endcase
			end
		endcase
	endfunction

	// Present one word and hold it until it is taken; gaps come between bursts.
	task automatic send_word(mm4_pkg::in_item_t w);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(1, 10);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
			                                         : $urandom_range(1, 12);
			// After a drain start is already low.
			if (start)
				start <= 1'b0;
			item  <= mm4_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		start <= 1'b1;
		item  <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		words_sent++;
	endtask

	// Send the four row pairs of mat_a and mat_b.
	task automatic send_matrix();
		mm4_pkg::in_item_t w;
		for (int r = 0; r < mm4_pkg::DIM; r++) begin
			w.a_col0 = mat_a[r][0];
			w.a_col1 = mat_a[r][1];
			w.a_col2 = mat_a[r][2];
			w.a_col3 = mat_a[r][3];
			w.b_col0 = mat_b[r][0];
			w.b_col1 = mat_b[r][1];
			w.b_col2 = mat_b[r][2];
			w.b_col3 = mat_b[r][3];
			send_word(w);
		end
		mats_sent++;
	endtask

	// Hold off the sender until every predicted row has come back.
	task automatic drain_all();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic fill_both(mm4_pkg::elem_t av, mm4_pkg::elem_t bv);
		for (int i = 0; i < mm4_pkg::DIM; i++)
			for (int j = 0; j < mm4_pkg::DIM; j++) begin
				mat_a[i][j] = av;
				mat_b[i][j] = bv;
			end
	endtask

	initial begin
		int style;
		start      = 1'b0;
		item       = '0;
		arst_n     = 1'b0;
		burst_left = 0;
		words_sent = 0;
		mats_sent  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: positive saturation from the largest operands.
		fill_both(mm4_pkg::elem_t'(32767), mm4_pkg::elem_t'(32767));
		send_matrix();
		// Negative saturation from opposite extremes.
		fill_both(mm4_pkg::elem_t'(32767), mm4_pkg::elem_t'(-32768));
		send_matrix();
		// Most negative times most negative also overflows upward.
		fill_both(mm4_pkg::elem_t'(-32768), mm4_pkg::elem_t'(-32768));
		send_matrix();
		// Identity times a full-range B must give B back unchanged.
		for (int i = 0; i < mm4_pkg::DIM; i++)
			for (int j = 0; j < mm4_pkg::DIM; j++) begin
				mat_a[i][j] = (i == j) ? mm4_pkg::elem_t'(256) : mm4_pkg::elem_t'(0);
				mat_b[i][j] = rand_elem(0);
			end
		send_matrix();
		// Tiny negative sum: the shift must round toward minus infinity.
		fill_both(mm4_pkg::elem_t'(-1), mm4_pkg::elem_t'(1));
		send_matrix();
		drain_all();

		// Random matrices, with an occasional full drain in between.
		for (int m = 0; m < RAND_MATS; m++) begin
			style = $urandom_range(0, 2);
			for (int i = 0; i < mm4_pkg::DIM; i++)
				for (int j = 0; j < mm4_pkg::DIM; j++) begin
					mat_a[i][j] = rand_elem(style);
					mat_b[i][j] = rand_elem(style);
				end
			send_matrix();
			if ($urandom_range(0, 7) == 0)
				drain_all();
		end

		// Let everything come back, then watch a little longer for stray results.
		drain_all();
		repeat (20) @(posedge clk);

		$display("Sent %0d words forming %0d matrix pairs under random bursts and gaps.",
			words_sent, mats_sent);
		$display("Checked %0d product rows, %0d elements clamped at the 16-bit limits.",
			rows_checked, sat_elems);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("Failures: %0d, rows still owed: %0d", fail_count, pending);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
